>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When ante holds at one edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/egt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// egt_pkg
// Types and constants of the elevation grid traversability block.
// ---------------------------------------------------------------------------
package egt_pkg;

    localparam int GRID_SIDE   = 256;
    localparam int HEIGHT_BITS = 24;

    localparam int COORD_BITS  = 9;
    localparam int DIM_BITS    = 9;
    localparam int LIMIT_BITS  = 23;
    localparam int IN_HEIGHT_BITS = 24;
    localparam int CFG_DATA_BITS  = 23;
    localparam int CFG_INDEX_BITS = 3;

    localparam int CELLS       = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_BITS   = $clog2(CELLS);
    localparam int CELL_BITS   = HEIGHT_BITS + 2;
    localparam int DIFF_BITS   = HEIGHT_BITS + 1;
    localparam int CMP_BITS    = (DIFF_BITS > LIMIT_BITS) ? DIFF_BITS : LIMIT_BITS;

    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 32;

    localparam logic [IN_HEIGHT_BITS-1:0] NO_GROUND_HEIGHT = 24'h7F_FFFF;

    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic [DIM_BITS-1:0]           t_dim;
    typedef logic [LIMIT_BITS-1:0]         t_limit;
    typedef logic [ADDR_BITS-1:0]          t_addr;
    typedef logic signed [HEIGHT_BITS-1:0] t_height;

    typedef enum logic [0:0] {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRID_WIDTH        = 3'd0,
        CFG_GRID_HEIGHT       = 3'd1,
        CFG_MAX_STEP          = 3'd2,
        CFG_MAX_RISE_STRAIGHT = 3'd3,
        CFG_MAX_RISE_DIAGONAL = 3'd4
    } t_cfg_reg;

    // One stored cell: obstacle mark, ground mark, height.
    typedef struct packed {
        logic    obstacle;
        logic    ground;
        t_height height;
    } t_cell;

endpackage

>>> rtl/core/egt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// egt_ram
// Generic RAM, one write port and two read ports with registered read data.
// ---------------------------------------------------------------------------
module egt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

>>> rtl/core/elevation_grid_traversability.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elevation_grid_traversability
// Grid of cells with height, ground and obstacle marks; loads cells and
// checks moves between two cells against step and slope limits.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s         in         tdata: cell write or move query, tuser: function
//  m         out        tdata: move verdict and target cell report
//  cfg       in         register writes: grid size, step and rise limits
//
//  One transaction is taken per cycle while o_s_tready is high. A result
//  passes first the cell store read registers (both cells read on the two
//  read ports at once), then the output register behind the check.
//  A write updates the store at its accept edge, so a following query sees
//  it. The check stage parts the store read from the output register, so
//  input is taken while a result waits; when both are full and the output
//  is stalled, o_s_tready falls. Reset clears only control state and the
//  configuration registers; the store is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module elevation_grid_traversability (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // from_x, from_y, to_x, to_y, ground_height, ground_present,
    // obstacle_present, zero pad (lowest bit first)
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [egt_pkg::S_TDATA_BITS-1:0]     i_s_tdata,
    // func
    input  logic                                 i_s_tuser,
    // move_ok, target_valid, target_has_ground, target_ground_height,
    // target_walkable, zero pad (lowest bit first)
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [egt_pkg::M_TDATA_BITS-1:0]     o_m_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [egt_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [egt_pkg::CFG_DATA_BITS-1:0]    i_cfg_wr_data
);

    import egt_pkg::*;

    // A cell is in the grid when both coordinates are non-negative, below
    // the configured size and below the store side.
    function automatic logic cell_valid(input t_coord x, input t_coord y,
                                        input t_dim w, input t_dim h);
        logic ok;
        ok = !x[COORD_BITS-1] && !y[COORD_BITS-1] &&
             ($unsigned(x) < w) && ($unsigned(y) < h) &&
             (32'($unsigned(x)) < GRID_SIDE) && (32'($unsigned(y)) < GRID_SIDE);
        return ok;
    endfunction

    function automatic t_addr cell_addr(input t_coord x, input t_coord y);
        t_addr a;
        a = ADDR_BITS'(x[COORD_BITS-2:0]) * ADDR_BITS'(GRID_SIDE)
            + ADDR_BITS'(y[COORD_BITS-2:0]);
        return a;
    endfunction

    // Configuration registers.
    t_dim   r_grid_width;
    t_dim   r_grid_height;
    t_limit r_max_step;
    t_limit r_max_rise_straight;
    t_limit r_max_rise_diagonal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width        <= DIM_BITS'(200);
            r_grid_height       <= DIM_BITS'(200);
            r_max_step          <= '0;
            r_max_rise_straight <= '0;
            r_max_rise_diagonal <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_WIDTH:        r_grid_width        <= i_cfg_wr_data[DIM_BITS-1:0];
                CFG_GRID_HEIGHT:       r_grid_height       <= i_cfg_wr_data[DIM_BITS-1:0];
                CFG_MAX_STEP:          r_max_step          <= i_cfg_wr_data;
                CFG_MAX_RISE_STRAIGHT: r_max_rise_straight <= i_cfg_wr_data;
                CFG_MAX_RISE_DIAGONAL: r_max_rise_diagonal <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transaction.
    t_coord                    s_from_x, s_from_y, s_to_x, s_to_y;
    logic [IN_HEIGHT_BITS-1:0] s_ground_height;
    logic                      s_ground_present, s_obstacle_present;
    t_func                     s_func;

    assign s_from_x           = i_s_tdata[8:0];
    assign s_from_y           = i_s_tdata[17:9];
    assign s_to_x             = i_s_tdata[26:18];
    assign s_to_y             = i_s_tdata[35:27];
    assign s_ground_height    = i_s_tdata[59:36];
    assign s_ground_present   = i_s_tdata[60];
    assign s_obstacle_present = i_s_tdata[61];
    assign s_func             = t_func'(i_s_tuser);

    // Pipeline control.
    logic r_s1_valid, r_out_valid;
    logic s1_advance, s_accept;

    assign s1_advance = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    logic  s_from_ok, s_to_ok;
    t_cell s_wr_cell, ram_to, ram_from;

    assign s_from_ok = cell_valid(s_from_x, s_from_y, r_grid_width, r_grid_height);
    assign s_to_ok   = cell_valid(s_to_x, s_to_y, r_grid_width, r_grid_height);

    assign s_wr_cell.obstacle = s_obstacle_present;
    assign s_wr_cell.ground   = s_ground_present;
    assign s_wr_cell.height   = HEIGHT_BITS'($signed(s_ground_height));

    // Cell store: port a reads the target, port b the start cell. The read
    // registers only load on an accept, so they hold through a stall.
    egt_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (CELLS)
    ) u_cell_store (
        .i_clk       (i_clk),
        .i_wr_en     (s_accept && (s_func == FUNC_WRITE) && s_from_ok),
        .i_wr_addr   (cell_addr(s_from_x, s_from_y)),
        .i_wr_data   (s_wr_cell),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (cell_addr(s_to_x, s_to_y)),
        .i_rd_addr_b (cell_addr(s_from_x, s_from_y)),
        .o_rd_data_a (ram_to),
        .o_rd_data_b (ram_from)
    );

    // Stage 1: the addressing results travel beside the store read.
    t_func r_s1_func;
    logic  r_s1_to_ok, r_s1_from_ok, r_s1_diag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_func    <= s_func;
            r_s1_to_ok   <= s_to_ok;
            r_s1_from_ok <= s_from_ok;
            r_s1_diag    <= (s_from_x != s_to_x) && (s_from_y != s_to_y);
        end
    end

    // Check: exact height difference, its magnitude against both limits.
    logic signed [DIFF_BITS-1:0] s1_diff;
    logic [CMP_BITS-1:0]         s1_mag, s1_step, s1_rise;
    logic                        s1_to_ground, s1_to_walk, s1_move_ok, s1_query;
    logic [IN_HEIGHT_BITS-1:0]   s1_height;

    always_comb begin
        s1_query     = (r_s1_func == FUNC_QUERY);
        s1_diff      = DIFF_BITS'(ram_to.height) - DIFF_BITS'(ram_from.height);
        s1_mag       = CMP_BITS'(unsigned'(s1_diff[DIFF_BITS-1] ? -s1_diff : s1_diff));
        s1_step      = CMP_BITS'(r_max_step);
        s1_rise      = CMP_BITS'(r_s1_diag ? r_max_rise_diagonal : r_max_rise_straight);
        s1_to_ground = r_s1_to_ok && ram_to.ground;
        s1_to_walk   = s1_to_ground && !ram_to.obstacle;
        s1_move_ok   = s1_to_walk && r_s1_from_ok && ram_from.ground &&
                       (s1_mag <= s1_step) && (s1_mag <= s1_rise);
        s1_height    = s1_to_ground ? IN_HEIGHT_BITS'(ram_to.height) : NO_GROUND_HEIGHT;
    end

    // Output register.
    logic                      r_out_move_ok, r_out_to_ok, r_out_ground, r_out_walk;
    logic [IN_HEIGHT_BITS-1:0] r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_move_ok <= s1_query && s1_move_ok;
            r_out_to_ok   <= s1_query && r_s1_to_ok;
            r_out_ground  <= s1_query && s1_to_ground;
            r_out_walk    <= s1_query && s1_to_walk;
            r_out_height  <= s1_query ? s1_height : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_walk, r_out_height,
                         r_out_ground, r_out_to_ok, r_out_move_ok};

    // A passed move needs a walkable target.
    `ASSERT_ALWAYS(a_ok_walkable, i_clk, i_rst_n,
        !r_out_valid || !r_out_move_ok || (r_out_walk && r_out_ground && r_out_to_ok),
        "move allowed onto a target that is not walkable")
    // With both stages full and the output stalled, no input is taken.
    `ASSERT_ALWAYS(a_no_overrun, i_clk, i_rst_n,
        !(r_s1_valid && r_out_valid && !i_m_tready) || !o_s_tready,
        "input taken while the pipeline is full")
    // A stalled check stage keeps its item.
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_m_tready,
        r_s1_valid && r_out_valid,
        "item lost during an output stall")

endmodule

>>> test/tb_elevation_grid_traversability.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_elevation_grid_traversability
// Self-checking bench for the elevation grid traversability block: loads
// cells, queries moves under several grid sizes and limits, and compares
// every reported field with an in-bench prediction of the grid.
// ---------------------------------------------------------------------------
module tb_elevation_grid_traversability;

    import egt_pkg::*;

    // Run ends with a failure if it goes on longer than this.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles allowed for the two-stage pipeline to settle before a register
    // write or the final verdict.
    localparam int SETTLE_CYCLES = 6;

    // Input transaction, highest field first, as laid out in tdata.
    typedef struct packed {
        logic [1:0] pad;
        logic       obstacle_present;
        logic       ground_present;
        t_height    ground_height;
        t_coord     to_y;
        t_coord     to_x;
        t_coord     from_y;
        t_coord     from_x;
    } t_request;

    // Result transaction, highest field first, as laid out in tdata.
    typedef struct packed {
        logic [3:0] pad;
        logic       walkable;
        t_height    ground_height;
        logic       has_ground;
        logic       target_valid;
        logic       move_ok;
    } t_move_report;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [S_TDATA_BITS-1:0]   i_s_tdata = '0;
    logic                      i_s_tuser = 1'b0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   o_m_tdata;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wr_data = '0;

    elevation_grid_traversability DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Shadow of the block: register settings as last written and the cell
    // store. The written marks let the stimulus steer clear of cells whose
    // content is still undefined.
    // -----------------------------------------------------------------------
    t_dim    grid_w = 9'd200;
    t_dim    grid_h = 9'd200;
    t_limit  step_limit = '0;
    t_limit  rise_straight = '0;
    t_limit  rise_diagonal = '0;

    t_height store_height   [CELLS];
    bit      store_ground   [CELLS];
    bit      store_obstacle [CELLS];
    bit      store_written  [CELLS];
    int      written_cells  [$];

    t_move_report expected_reports [$];
    t_move_report observed_report;
    t_move_report wanted_report;

    int errors = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int hold_cycles_left = 0;

    function automatic bit cell_in_grid(t_coord x, t_coord y);
        return int'(x) >= 0 && int'(y) >= 0 &&
               int'(x) < int'(grid_w) && int'(y) < int'(grid_h);
    endfunction

    function automatic int cell_index(t_coord x, t_coord y);
        return int'(x) * GRID_SIDE + int'(y);
    endfunction

    // Works out the report for one accepted transaction. A cell write also
    // updates the shadow store, so calls must follow the order of acceptance.
    function automatic t_move_report predict_report(t_func f, t_request r);
        t_move_report rep;
        bit tv, fv, tg, tob, fg, ok;
        int ti, fi, diff, rise;
        rep = '0;
        if (f == FUNC_WRITE) begin
            if (cell_in_grid(r.from_x, r.from_y)) begin
                fi = cell_index(r.from_x, r.from_y);
                if (!store_written[fi])
                    written_cells.push_back(fi);
                store_written[fi]  = 1'b1;
                store_height[fi]   = r.ground_height;
                store_ground[fi]   = r.ground_present;
                store_obstacle[fi] = r.obstacle_present;
            end
            return rep;
        end
        tv = cell_in_grid(r.to_x, r.to_y);
        fv = cell_in_grid(r.from_x, r.from_y);
        tg = 1'b0;
        tob = 1'b0;
        fg = 1'b0;
        ti = 0;
        fi = 0;
        if (tv) begin
            ti  = cell_index(r.to_x, r.to_y);
            tg  = store_ground[ti];
            tob = store_obstacle[ti];
        end
        if (fv) begin
            fi = cell_index(r.from_x, r.from_y);
            fg = store_ground[fi];
        end
        ok = tv && fv && tg && !tob && fg;
        if (ok) begin
            // The difference of two 24-bit heights needs 25 bits; an int
            // holds it exactly.
            diff = int'(store_height[ti]) - int'(store_height[fi]);
            if (diff < 0)
                diff = -diff;
            rise = (r.from_x != r.to_x && r.from_y != r.to_y) ?
                   int'(rise_diagonal) : int'(rise_straight);
            if (diff > int'(step_limit) || diff > rise)
                ok = 1'b0;
        end
        rep.move_ok       = ok;
        rep.target_valid  = tv;
        rep.has_ground    = tv && tg;
        rep.ground_height = (tv && tg) ? store_height[ti] : t_height'(NO_GROUND_HEIGHT);
        rep.walkable      = tv && tg && !tob;
        return rep;
    endfunction

    // -----------------------------------------------------------------------
    // Clock-cycle watchdog.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ERROR timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver. Normally ready is drawn at random each cycle; when a hold is
    // requested it stays low for that many cycles so that the pipeline fills
    // up and the block has to refuse input.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_cycles_left > 0) begin
            i_m_tready <= 1'b0;
            hold_cycles_left = hold_cycles_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ERROR %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Result checker. Each output transaction is matched against the oldest
    // prediction still waiting. Signals are sampled at the edge, before the
    // block's own updates for that edge take effect.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            observed_report = t_move_report'(o_m_tdata);
            if (expected_reports.size() == 0) begin
                $display("%0t ERROR result with no expectation waiting: expected none, actual %h",
                         $time, o_m_tdata);
                errors++;
            end else begin
                wanted_report = expected_reports.pop_front();
                compare_field("move_ok", 32'(wanted_report.move_ok),
                              32'(observed_report.move_ok));
                compare_field("target_valid", 32'(wanted_report.target_valid),
                              32'(observed_report.target_valid));
                compare_field("target_has_ground", 32'(wanted_report.has_ground),
                              32'(observed_report.has_ground));
                compare_field("target_ground_height", 32'(wanted_report.ground_height),
                              32'(observed_report.ground_height));
                compare_field("target_walkable", 32'(wanted_report.walkable),
                              32'(observed_report.walkable));
                compare_field("tdata padding", 32'(wanted_report.pad),
                              32'(observed_report.pad));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sender: offers one transaction, with random idle cycles beforehand, and
    // records the prediction at the edge where it is accepted. Valid stays
    // high between back-to-back transactions.
    // -----------------------------------------------------------------------
    task automatic send_item(t_func f, t_request req);
        if ($urandom_range(99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < s_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        expected_reports.push_back(predict_report(f, req));
        items_sent++;
    endtask

    task automatic write_cell(t_coord x, t_coord y, t_height h, bit g, bit o);
        t_request req;
        req = '0;
        req.from_x = x;
        req.from_y = y;
        // Target fields mean nothing for a write; fill them with noise.
        req.to_x = t_coord'($urandom());
        req.to_y = t_coord'($urandom());
        req.ground_height = h;
        req.ground_present = g;
        req.obstacle_present = o;
        send_item(FUNC_WRITE, req);
    endtask

    task automatic query_move(t_coord fx, t_coord fy, t_coord tx, t_coord ty);
        t_request req;
        req = '0;
        req.from_x = fx;
        req.from_y = fy;
        req.to_x = tx;
        req.to_y = ty;
        req.ground_height = t_height'($urandom());
        req.ground_present = $urandom_range(1);
        req.obstacle_present = $urandom_range(1);
        send_item(FUNC_QUERY, req);
    endtask

    // Stops offering input and waits until every result has come back.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg r, logic [CFG_DATA_BITS-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= r;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
    endtask

    // Writes all five registers; only called with the pipeline empty.
    task automatic set_config(t_dim w, t_dim h, t_limit st, t_limit rs, t_limit rd);
        write_register(CFG_GRID_WIDTH, CFG_DATA_BITS'(w));
        write_register(CFG_GRID_HEIGHT, CFG_DATA_BITS'(h));
        write_register(CFG_MAX_STEP, st);
        write_register(CFG_MAX_RISE_STRAIGHT, rs);
        write_register(CFG_MAX_RISE_DIAGONAL, rd);
        i_cfg_wr_en <= 1'b0;
        grid_w = w;
        grid_h = h;
        step_limit = st;
        rise_straight = rs;
        rise_diagonal = rd;
        @(posedge i_clk);
    endtask

    // A cell inside the grid that was never written must not be queried, so
    // such a pick is mirrored into negative x, which is always outside.
    function automatic void make_readable(inout t_coord x, inout t_coord y);
        if (cell_in_grid(x, y) && !store_written[cell_index(x, y)])
            x = t_coord'(-int'(x) - 1);
    endfunction

    function automatic void pick_query_cell(output t_coord x, output t_coord y);
        int sel, idx;
        sel = $urandom_range(9);
        if (sel < 7 && written_cells.size() != 0) begin
            idx = written_cells[$urandom_range(written_cells.size() - 1)];
            x = t_coord'(idx / GRID_SIDE);
            y = t_coord'(idx % GRID_SIDE);
            if (sel >= 4) begin
                // A neighbour of a known cell, often across the grid edge.
                x = t_coord'(int'(x) + int'($urandom_range(2)) - 1);
                y = t_coord'(int'(y) + int'($urandom_range(2)) - 1);
            end
        end else begin
            x = t_coord'($urandom());
            y = t_coord'($urandom());
        end
        make_readable(x, y);
    endfunction

    // Well-formed traffic: load a 3x3 patch with heights clustered around
    // the current limits, then query moves between its cells.
    task automatic send_patch_sequence();
        t_coord px [9];
        t_coord py [9];
        t_coord cx, cy;
        int span, base, off, lim, k, a, b;
        cx = t_coord'($urandom_range(int'(grid_w) - 1));
        cy = t_coord'($urandom_range(int'(grid_h) - 1));
        lim = int'(step_limit);
        if (int'(rise_straight) > lim)
            lim = int'(rise_straight);
        if (int'(rise_diagonal) > lim)
            lim = int'(rise_diagonal);
        span = (lim < 1000000) ? lim + 2 : 8388607;
        base = int'($urandom());
        for (k = 0; k < 9; k++) begin
            px[k] = t_coord'(int'(cx) + k % 3 - 1);
            py[k] = t_coord'(int'(cy) + k / 3 - 1);
            off = int'($urandom_range(2 * span));
            write_cell(px[k], py[k], t_height'(base + off - span),
                       $urandom_range(9) != 0, $urandom_range(99) < 15);
        end
        for (k = 0; k < 6; k++) begin
            a = $urandom_range(3) == 0 ? $urandom_range(8) : 4;
            b = $urandom_range(8);
            query_move(px[a], py[a], px[b], py[b]);
        end
    endtask

    // Noise: a write anywhere in the coordinate range, or a query between
    // loosely chosen cells.
    task automatic send_noise_item();
        t_coord fx, fy, tx, ty;
        if ($urandom_range(1) == 0) begin
            write_cell(t_coord'($urandom()), t_coord'($urandom()), t_height'($urandom()),
                       $urandom_range(1), $urandom_range(1));
        end else begin
            pick_query_cell(fx, fy);
            pick_query_cell(tx, ty);
            query_move(fx, fy, tx, ty);
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Registers as left by reset: 200 x 200 grid, every limit zero, so only
    // level moves pass.
    task automatic test_reset_defaults();
        write_cell(9'sd0, 9'sd0, 24'sd7, 1'b1, 1'b0);
        write_cell(9'sd0, 9'sd1, 24'sd7, 1'b1, 1'b0);
        write_cell(9'sd0, 9'sd2, 24'sd8, 1'b1, 1'b0);
        write_cell(9'sd199, 9'sd199, -24'sd3, 1'b1, 1'b0);
        // Just outside the default grid: ignored.
        write_cell(9'sd200, 9'sd5, 24'sd0, 1'b1, 1'b0);
        query_move(9'sd0, 9'sd0, 9'sd0, 9'sd1);
        query_move(9'sd0, 9'sd0, 9'sd0, 9'sd2);
        query_move(9'sd199, 9'sd199, 9'sd200, 9'sd5);
    endtask

    // Step and slope rules, straight and diagonal, exact limits, extreme
    // heights and coordinates, missing ground and obstacles.
    task automatic test_move_rules();
        wait_for_results();
        set_config(9'd256, 9'd256, 23'd20, 23'd10, 23'd14);
        write_cell(9'sd1, 9'sd0, 24'sd10, 1'b1, 1'b0);
        write_cell(9'sd1, 9'sd1, 24'sd14, 1'b1, 1'b0);
        write_cell(9'sd255, 9'sd255, -24'sd8388608, 1'b1, 1'b1);
        write_cell(9'sd254, 9'sd254, 24'sd8388607, 1'b1, 1'b0);
        write_cell(9'sd2, 9'sd0, 24'sd5, 1'b1, 1'b1);
        write_cell(9'sd0, 9'sd3, 24'sd7, 1'b0, 1'b0);
        write_cell(-9'sd256, -9'sd256, 24'sd1, 1'b1, 1'b0);
        // Cell 0,0 is reloaded at height 0: a straight rise of exactly the
        // straight limit passes, and a diagonal gets the larger limit.
        write_cell(9'sd0, 9'sd0, 24'sd0, 1'b1, 1'b0);
        query_move(9'sd0, 9'sd0, 9'sd1, 9'sd0);
        query_move(9'sd0, 9'sd0, 9'sd0, 9'sd1);
        query_move(9'sd0, 9'sd0, 9'sd1, 9'sd1);
        query_move(9'sd254, 9'sd254, 9'sd255, 9'sd255);
        query_move(9'sd0, 9'sd0, 9'sd2, 9'sd0);
        query_move(9'sd0, 9'sd0, 9'sd0, 9'sd3);
        query_move(9'sd0, 9'sd3, 9'sd0, 9'sd0);
        // A move onto the same cell counts as a straight move of zero.
        query_move(9'sd1, 9'sd1, 9'sd1, 9'sd1);
        query_move(9'sd0, 9'sd0, -9'sd256, -9'sd256);
        query_move(-9'sd1, 9'sd0, 9'sd0, 9'sd0);
        query_move(9'sd255, -9'sd256, 9'sd254, 9'sd254);
    endtask

    // A step limit tighter than the slope limit decides on its own.
    task automatic test_step_limit();
        wait_for_results();
        set_config(9'd256, 9'd256, 23'd8, 23'd10, 23'd14);
        query_move(9'sd0, 9'sd0, 9'sd1, 9'sd0);
        query_move(9'sd1, 9'sd0, 9'sd0, 9'sd0);
    endtask

    // With a zero grid size no cell is valid: queries report an invalid
    // target and writes leave the store alone.
    task automatic test_empty_grid();
        wait_for_results();
        set_config(9'd0, 9'd0, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        write_cell(9'sd0, 9'sd0, 24'sd99, 1'b0, 1'b1);
        query_move(9'sd0, 9'sd0, 9'sd1, 9'sd0);
        wait_for_results();
        set_config(9'd256, 9'd256, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        query_move(9'sd1, 9'sd0, 9'sd0, 9'sd0);
    endtask

    // Random traffic under one register setting, mostly patch sequences.
    task automatic test_random_traffic(t_dim w, t_dim h, t_limit st, t_limit rs,
                                       t_limit rd, int n_items);
        int stop_at;
        wait_for_results();
        set_config(w, h, st, rs, rd);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 7)
                send_patch_sequence();
            else
                send_noise_item();
        end
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering transactions, so the block must fill up and stall its input.
    task automatic test_output_stall();
        int k;
        wait_for_results();
        s_idle_pct = 0;
        m_idle_pct = 0;
        hold_cycles_left = 300;
        for (k = 0; k < 3; k++)
            send_patch_sequence();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender seldom idle, receiver mostly stalled.
        s_idle_pct = 15;
        m_idle_pct = 68;
        test_reset_defaults();
        test_move_rules();
        test_step_limit();
        test_empty_grid();
        test_random_traffic(9'd256, 9'd256, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 200);
        test_random_traffic(9'd10, 9'd10, 23'd0, 23'd0, 23'd0, 120);

        // Sender mostly idle, receiver seldom stalled.
        wait_for_results();
        s_idle_pct = 68;
        m_idle_pct = 15;
        test_random_traffic(9'd10, 9'd256, t_limit'($urandom_range(2000)),
                            t_limit'($urandom_range(1500)), t_limit'($urandom_range(2500)),
                            150);
        test_random_traffic(9'd256, 9'd10, t_limit'($urandom()),
                            t_limit'($urandom_range(100)), t_limit'($urandom_range(150)), 150);

        // Neither side idles.
        wait_for_results();
        s_idle_pct = 0;
        m_idle_pct = 0;
        test_random_traffic(9'd256, 9'd256, t_limit'($urandom_range(300)),
                            t_limit'($urandom_range(200)), t_limit'($urandom_range(300)), 280);
        test_output_stall();

        wait_for_results();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
